/* rtl/mcbt_pkg.sv */
// Shared types and constants for the multi-channel blink timer.
// Holds the transaction structs, action and status codes and the per-channel command struct.
// No dependencies; every other file of the block imports it.
package mcbt_pkg;

  localparam int unsigned CNT_W   = 12;
  localparam int unsigned PIN_W   = 9;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned MS_W    = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Action codes; the fourth code is unused and does nothing.
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_PROGRAM = 2'd1;
  localparam logic [1:0] ACT_SET     = 2'd2;

  // Status codes.
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_BAD_CHANNEL = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [CHAN_W-1:0] channel;
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   off_ms;
    logic [MS_W-1:0]   duration_ms;
    logic              level;
  } cmd_item_t;

  typedef struct packed {
    logic             status;
    logic [PIN_W-1:0] pin_levels;
  } rsp_item_t;

  // Update request for one channel, already qualified by the transaction that fires.
  typedef struct packed {
    logic             tick;
    logic             load;
    logic             set_pin;
    logic             level;
    logic [CNT_W-1:0] on_t;
    logic [CNT_W-1:0] off_t;
    logic [CNT_W-1:0] dur_t;
  } chan_cmd_t;

endpackage

/* rtl/mcbt_ms_to_ticks.sv */
// Millisecond to tick conversion for one time field of a program transaction.
// Raises sub-tick values by one tick, divides by TICK_MS through a reciprocal multiply, saturates.
// Depends on mcbt_pkg.
module mcbt_ms_to_ticks
  import mcbt_pkg::*;
#(
  parameter int unsigned TICK_MS = 20
) (
  input  logic [MS_W-1:0]  ms,
  output logic [CNT_W-1:0] ticks
);

  localparam int unsigned T_W     = MS_W + 1;
  localparam int unsigned QSHIFT  = T_W + 10;
  localparam int unsigned RECIP_W = QSHIFT + 1;
  localparam int unsigned PROD_W  = T_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << QSHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [T_W-1:0]    raised;
  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    quot;

  always_comb begin
    if ((ms != '0) && ({1'b0, ms} < T_W'(TICK_MS))) begin
      raised = {1'b0, ms} + T_W'(TICK_MS);
    end else begin
      raised = {1'b0, ms};
    end
    // Rounded-up reciprocal: exact for every raised value below 2**T_W.
    prod = PROD_W'(raised) * PROD_W'(RECIP);
    quot = prod[QSHIFT +: T_W];
    if (quot > T_W'(CNT_MAX)) begin
      ticks = CNT_MAX;
    end else begin
      ticks = quot[CNT_W-1:0];
    end
  end

endmodule

/* rtl/mcbt_channel.sv */
// One blink channel: reload values, running counters and the pin level.
// Applies tick, program and direct-set requests; exposes the current and next pin level.
// Depends on mcbt_pkg.
module mcbt_channel
  import mcbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  chan_cmd_t cmd,
  output logic      pin,
  output logic      pin_next
);

  logic [CNT_W-1:0] on_reload, on_reload_next;
  logic [CNT_W-1:0] off_reload, off_reload_next;
  logic [CNT_W-1:0] duration_left, duration_left_next;
  logic [CNT_W-1:0] on_left, on_left_next;
  logic [CNT_W-1:0] off_left, off_left_next;
  logic [CNT_W-1:0] dur_dec;
  logic             same;

  always_comb begin
    on_reload_next     = on_reload;
    off_reload_next    = off_reload;
    duration_left_next = duration_left;
    on_left_next       = on_left;
    off_left_next      = off_left;
    pin_next           = pin;
    dur_dec            = duration_left - CNT_W'(1);
    same = (on_reload == cmd.on_t) && (off_reload == cmd.off_t) &&
           (duration_left == cmd.dur_t);

    if (cmd.tick) begin
      if (duration_left != '0) begin
        duration_left_next = dur_dec;
        if (dur_dec == '0) begin
          pin_next = 1'b0;
        end else if (pin) begin
          if (off_reload != '0) begin
            if (on_left != '0) begin
              on_left_next = on_left - CNT_W'(1);
            end else begin
              pin_next      = 1'b0;
              off_left_next = off_reload;
            end
          end
        end else begin
          if (on_reload != '0) begin
            if (off_left != '0) begin
              off_left_next = off_left - CNT_W'(1);
            end else begin
              pin_next     = 1'b1;
              on_left_next = on_reload;
            end
          end
        end
      end
    end else if (cmd.load) begin
      if (!same) begin
        on_reload_next     = cmd.on_t;
        off_reload_next    = cmd.off_t;
        duration_left_next = cmd.dur_t;
        on_left_next       = cmd.on_t;
        off_left_next      = cmd.off_t;
        pin_next           = (cmd.on_t != '0);
      end
    end else if (cmd.set_pin) begin
      pin_next = cmd.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_reload     <= '0;
      off_reload    <= '0;
      duration_left <= '0;
      on_left       <= '0;
      off_left      <= '0;
      pin           <= 1'b0;
    end else begin
      on_reload     <= on_reload_next;
      off_reload    <= off_reload_next;
      duration_left <= duration_left_next;
      on_left       <= on_left_next;
      off_left      <= off_left_next;
      pin           <= pin_next;
    end
  end

endmodule

/* rtl/multi_channel_blink_timer_core.sv */
// Multi-channel blink timer. Each of NUM_CHANNELS outputs has an on-time, an off-time and a
// total duration, counted in ticks of TICK_MS milliseconds. A command transaction either
// advances every channel by one tick, programs one channel's times in milliseconds (raised
// to one tick when nonzero and shorter, then converted and saturated at 4095 ticks; an
// identical setting is ignored), or forces one pin. Each command returns exactly one
// response with a status (bad channel index on program or set) and the levels of the first
// nine pins after the command took effect. The core takes one command per clock cycle while
// the response register is not held by a stall. A command passes through the command
// register and then the single update stage, which applies the conversion multipliers and
// all channel counters and writes the response register.
// Depends on mcbt_pkg, mcbt_ms_to_ticks and mcbt_channel.
module multi_channel_blink_timer_core
  import mcbt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 9,
  parameter int unsigned TICK_MS      = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  // Command register: holds one accepted transaction until the update stage takes it.
  logic      s1_valid;
  cmd_item_t s1_item;

  logic      rsp_free;
  logic      fire;
  logic      in_range;
  logic      bad_channel;

  logic [CNT_W-1:0] on_t, off_t, dur_t;

  chan_cmd_t               chan_cmd [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pin_now;
  logic [NUM_CHANNELS-1:0] pin_next;
  logic [PIN_W-1:0]        pin_vec_now;
  logic [PIN_W-1:0]        pin_vec_next;

  // The update stage fires when the response register is empty or is being drained.
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && rsp_free;
  assign cmd_stall = s1_valid && !rsp_free;

  assign in_range    = {1'b0, s1_item.channel} < (CHAN_W + 1)'(NUM_CHANNELS);
  assign bad_channel = !in_range &&
                       ((s1_item.action == ACT_PROGRAM) || (s1_item.action == ACT_SET));

  // Convert the three program times side by side.
  mcbt_ms_to_ticks #(.TICK_MS(TICK_MS)) u_on_conv (
    .ms    (s1_item.on_ms),
    .ticks (on_t)
  );

  mcbt_ms_to_ticks #(.TICK_MS(TICK_MS)) u_off_conv (
    .ms    (s1_item.off_ms),
    .ticks (off_t)
  );

  mcbt_ms_to_ticks #(.TICK_MS(TICK_MS)) u_dur_conv (
    .ms    (s1_item.duration_ms),
    .ticks (dur_t)
  );

  // One channel instance per output; a tick reaches all, program and set reach one.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    logic sel;

    assign sel = (s1_item.channel == CHAN_W'(i));

    always_comb begin
      chan_cmd[i].tick    = fire && (s1_item.action == ACT_TICK);
      chan_cmd[i].load    = fire && sel && (s1_item.action == ACT_PROGRAM);
      chan_cmd[i].set_pin = fire && sel && (s1_item.action == ACT_SET);
      chan_cmd[i].level   = s1_item.level;
      chan_cmd[i].on_t    = on_t;
      chan_cmd[i].off_t   = off_t;
      chan_cmd[i].dur_t   = dur_t;
    end

    mcbt_channel u_chan (
      .clk      (clk),
      .rst      (rst),
      .cmd      (chan_cmd[i]),
      .pin      (pin_now[i]),
      .pin_next (pin_next[i])
    );
  end

  // Report only the first nine pins; missing channels read as off.
  for (genvar b = 0; b < PIN_W; b++) begin : g_pin_vec
    if (b < NUM_CHANNELS) begin : g_used
      assign pin_vec_now[b]  = pin_now[b];
      assign pin_vec_next[b] = pin_next[b];
    end else begin : g_unused
      assign pin_vec_now[b]  = 1'b0;
      assign pin_vec_next[b] = 1'b0;
    end
  end

  // Advance the command register: load on accept, drop once the update stage takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_item <= cmd;
    end
  end

  // Response register: hold while stalled, capture the post-update pin vector on fire.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status     <= bad_channel ? STATUS_BAD_CHANNEL : STATUS_OK;
      rsp.pin_levels <= pin_vec_next;
    end
  end

  // A stalled command side only ever comes from a full, stalled response register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (s1_valid && rsp_valid && rsp_stall))
    else $error("command stall without a held response");

  // A rejected program or set leaves every pin as it was.
  a_bad_keeps_pins: assert property (@(posedge clk) disable iff (rst)
    (fire && bad_channel) |=>
      (rsp.status == STATUS_BAD_CHANNEL) && (rsp.pin_levels == $past(pin_vec_now)))
    else $error("rejected transaction changed pins or status");

  // A tick transaction always reports success.
  a_tick_ok: assert property (@(posedge clk) disable iff (rst)
    (fire && (s1_item.action == ACT_TICK)) |=> (rsp.status == STATUS_OK))
    else $error("tick transaction reported an error");

endmodule
